@@ rtl/core/qse_pkg.sv @@
// qse_pkg: shared types, character constants and the hex digit table
// for the quoted string escaper. No dependencies.
package qse_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7F;

  // One input transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  // One output transaction
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_ESC,
    CLS_HEX,
    CLS_CLOSE
  } cls_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic       open_quote;
    cls_t       cls;
    logic [7:0] data_byte;
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    case (nib)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'hA: ch = 8'h41;
      4'hB: ch = 8'h42;
      4'hC: ch = 8'h43;
      4'hD: ch = 8'h44;
      4'hE: ch = 8'h45;
      default: ch = 8'h46;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/qse_front.sv @@
// qse_front: accepts input transactions, tracks the opening quote and
// classifies each byte. Depends on qse_pkg.
module qse_front import qse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_item_t item,
  input  logic     q_full,
  output logic     push,
  output desc_t    desc
);

  logic quote_opened;
  logic accept;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign push       = accept;

  always_comb begin
    desc.open_quote = !quote_opened;
    desc.data_byte  = item.data_byte;
    if (item.kind) begin
      desc.cls = CLS_CLOSE;
    end else if (item.data_byte == CH_BSLASH || item.data_byte == CH_QUOTE) begin
      desc.cls = CLS_ESC;
    end else if (item.data_byte < PRINT_LO || item.data_byte >= PRINT_HI) begin
      desc.cls = CLS_HEX;
    end else begin
      desc.cls = CLS_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_opened <= 1'b0;
    end else if (accept) begin
      quote_opened <= !item.kind;
    end
  end

endmodule

@@ rtl/core/qse_queue.sv @@
// qse_queue: small FIFO of classified items between front and back.
// Depends on qse_pkg.
module qse_queue import qse_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t wr_desc,
  input  logic  pop,
  output desc_t rd_desc,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_desc = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/qse_back.sv @@
// qse_back: expands the queue head into escaped characters, one per
// cycle unless stalled, to the output register. Depends on qse_pkg.
module qse_back import qse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  desc_t     head,
  output logic      pop,
  output logic      text_valid,
  input  logic      text_stall,
  output out_item_t text
);

  logic [2:0] step;
  logic [2:0] rel;
  logic [2:0] last_step;
  logic       at_last;
  logic       load;
  logic [7:0] ch;

  assign rel = step - {2'b00, head.open_quote};

  always_comb begin
    unique case (head.cls)
      CLS_PLAIN: last_step = 3'd0;
      CLS_ESC:   last_step = 3'd1;
      CLS_HEX:   last_step = 3'd3;
      CLS_CLOSE: last_step = 3'd0;
      default:   last_step = 3'd0;
    endcase
    last_step = last_step + {2'b00, head.open_quote};
  end

  always_comb begin
    if (head.open_quote && step == 3'd0) begin
      ch = CH_QUOTE;
    end else begin
      case (head.cls)
        CLS_PLAIN: ch = head.data_byte;
        CLS_ESC:   ch = (rel == 3'd0) ? CH_BSLASH : head.data_byte;
        CLS_HEX: begin
          case (rel)
            3'd0:    ch = CH_BSLASH;
            3'd1:    ch = CH_X;
            3'd2:    ch = hex_digit(head.data_byte[7:4]);
            default: ch = hex_digit(head.data_byte[3:0]);
          endcase
        end
        default:   ch = CH_QUOTE;
      endcase
    end
  end

  assign at_last = (step == last_step);
  assign load    = !q_empty && (!text_valid || !text_stall);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      text_valid <= 1'b0;
    end else if (load) begin
      step       <= at_last ? 3'd0 : step + 3'd1;
      text_valid <= 1'b1;
    end else if (!text_stall) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text.out_char    <= ch;
      text.run_last    <= at_last;
      text.string_done <= at_last && (head.cls == CLS_CLOSE);
    end
  end

endmodule

@@ rtl/core/quoted_string_escaper.sv @@
// quoted_string_escaper: top level, front classifier, item queue and
// character back end. Depends on qse_pkg, qse_front, qse_queue, qse_back.
//
// Turns a stream of byte transactions into a double-quoted literal, one
// output transaction per character. Printable bytes pass unchanged,
// backslash and double quote gain a leading backslash, and bytes below
// 0x20 or from 0x7F up become backslash, x and two upper-case hex digits.
// The opening quote is emitted ahead of the first character of a string;
// an end-of-string transaction emits the closing quote (two quotes for an
// empty string) with string_done set. run_last marks the final character
// caused by each input transaction. The back end emits one character per
// cycle while the output is not stalled, and an item yields one to five
// characters; the front accepts one transaction per cycle while the
// queue of QUEUE_DEPTH classified items has room. The output register
// holds a character while it waits to be taken, and the next one is
// loaded in the cycle it is taken, so a stalled output halts the back
// end. An accepted transaction is written into the queue, and its first
// character is loaded into the output register once the item is at the
// queue head and the output register is free.
module quoted_string_escaper import qse_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      text_valid,
  input  logic      text_stall,
  output out_item_t text
);

  // Front to queue
  logic  push;
  desc_t wr_desc;
  // Queue to back
  logic  q_full;
  logic  q_empty;
  logic  pop;
  desc_t head;

  // Classify and hold quote state
  qse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .desc       (wr_desc)
  );

  // Decouple acceptance from character expansion
  qse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_desc (wr_desc),
    .pop     (pop),
    .rd_desc (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Expand the head item, one character a cycle while not stalled
  qse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

endmodule

@@ tb/sv/quoted_string_escaper_tb.sv @@
// quoted_string_escaper_tb: self-checking bench for the quoted string escaper.
// Depends on qse_pkg and the quoted_string_escaper RTL. Drives byte and
// end-of-string transactions, predicts the escaped text, checks every character.
module quoted_string_escaper_tb;
  import qse_pkg::*;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Slowest correct run: ~530 items x 5 characters, each held up by random
  // output stalls, plus the long hold. Take that many times over.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 80;
  localparam int CALM_TAIL    = 60;
  localparam int TAIL_CYCLES  = 20;
  localparam int DRAIN_AT_A   = 16;
  localparam int DRAIN_AT_B   = 270;
  localparam int RANDOM_ITEMS = 500;

  typedef struct {
    in_item_t body;
    bit       drain_first;  // hold this transaction until all text has arrived
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      text_valid;
  logic      text_stall = 1'b0;
  out_item_t text;

  pending_t  pending_items[$];
  out_item_t expected_text[$];
  logic      quote_open = 1'b0;   // predictor's copy of the opening-quote state
  logic      calm = 1'b0;         // set for the tail of the run: no idling
  int        errors = 0;
  int        cycles = 0;

  quoted_string_escaper u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t text_char(input logic [7:0] c, input logic done);
    out_item_t t;
    t.out_char    = c;
    t.run_last    = 1'b0;
    t.string_done = done;
    return t;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
  endfunction

  // Predict the characters one accepted transaction produces and queue them.
  // The opening quote goes first whenever no string is open; an end item
  // closes the string, so an empty string yields two quotes.
  function automatic void escape_item(input in_item_t it);
    out_item_t  seq [5];
    int         n;
    logic [7:0] b;
    n = 0;
    b = it.data_byte;
    if (!quote_open) begin
      seq[n] = text_char(CH_QUOTE, 1'b0);
      n++;
      quote_open = 1'b1;
    end
    if (it.kind == KIND_END) begin
      seq[n] = text_char(CH_QUOTE, 1'b1);
      n++;
      quote_open = 1'b0;
    end else if (b == CH_BSLASH || b == CH_QUOTE) begin
      seq[n] = text_char(CH_BSLASH, 1'b0);
      seq[n+1] = text_char(b, 1'b0);
      n += 2;
    end else if (b < PRINT_LO || b >= PRINT_HI) begin
      // unsigned hex value, upper-case digits
      seq[n] = text_char(CH_BSLASH, 1'b0);
      seq[n+1] = text_char(CH_X, 1'b0);
      seq[n+2] = text_char(hex_char(b[7:4]), 1'b0);
      seq[n+3] = text_char(hex_char(b[3:0]), 1'b0);
      n += 4;
    end else begin
      seq[n] = text_char(b, 1'b0);
      n++;
    end
    seq[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++)
      expected_text.push_back(seq[i]);
  endfunction

  function automatic void queue_item(input logic kind, input logic [7:0] b);
    pending_t p;
    p.body.kind      = kind;
    p.body.data_byte = b;
    p.drain_first    = (pending_items.size() == DRAIN_AT_A) ||
                       (pending_items.size() == DRAIN_AT_B);
    pending_items.push_back(p);
  endfunction

  // Bias bytes towards the escape classes so each path is hit often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0, 1:    return 8'($urandom_range(32'h20, 32'h7E));
      2:       return $urandom_range(0, 1) ? CH_BSLASH : CH_QUOTE;
      3:       return 8'($urandom_range(32'h00, 32'h1F));
      4:       return 8'($urandom_range(32'h7F, 32'hFF));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Driver: present the next pending transaction, hold it while stalled,
  // and insert random idle bursts between transactions.
  always @(posedge clk) begin : drive_items
    logic next_valid;
    int   send_gap;
    next_valid = item_valid;
    if (rst) begin
      next_valid = 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall) begin
        escape_item(item);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          // this cycle is the first of the burst
          send_gap = $urandom_range(1, 9) - 1;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain_first && expected_text.size() != 0)) begin
          item <= pending_items[0].body;
          pending_items.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    item_valid <= next_valid;
  end

  // Monitor: check each accepted character against the oldest prediction,
  // then decide the stall for the next cycle. One long hold early in the
  // run lets the block fill up and push back on its input.
  always @(posedge clk) begin : check_text
    logic      next_stall;
    out_item_t want;
    int        stall_gap;
    int        hold_left;
    bit        hold_done;
    int        chars_seen;
    next_stall = text_stall;
    if (rst) begin
      next_stall = 1'b0;
      stall_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
      chars_seen = 0;
    end else begin
      if (text_valid && !text_stall) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          errors++;
          $display("%0t: unexpected character: expected none, actual char=%h last=%b done=%b",
                   $time, text.out_char, text.run_last, text.string_done);
        end else begin
          want = expected_text.pop_front();
          if (text.out_char !== want.out_char || text.run_last !== want.run_last ||
              text.string_done !== want.string_done) begin
            errors++;
            $display("%0t: text mismatch: expected char=%h last=%b done=%b, actual char=%h last=%b done=%b",
                     $time, want.out_char, want.run_last, want.string_done,
                     text.out_char, text.run_last, text.string_done);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (!hold_done && chars_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        next_stall = 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        next_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(1, 9) - 1;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
    end
    text_stall <= next_stall;
  end

  // Watchdog: abandon a run that has hung.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[quoted_string_escaper] ERROR");
      $finish;
    end
  end

  initial begin : run_test
    int len;
    // Directed: empty strings (data byte ignored), the class boundaries,
    // both escaped characters, a bare 'x', then a one-character string.
    queue_item(KIND_END, 8'hA5);
    queue_item(KIND_END, 8'h00);
    queue_item(KIND_DATA, 8'h00);
    queue_item(KIND_DATA, 8'h1F);
    queue_item(KIND_DATA, 8'h20);
    queue_item(KIND_DATA, 8'h7E);
    queue_item(KIND_DATA, 8'h7F);
    queue_item(KIND_DATA, 8'h80);
    queue_item(KIND_DATA, 8'hFF);
    queue_item(KIND_DATA, CH_BSLASH);
    queue_item(KIND_DATA, CH_QUOTE);
    queue_item(KIND_DATA, 8'h41);
    queue_item(KIND_DATA, CH_X);
    queue_item(KIND_END, 8'hFF);
    queue_item(KIND_DATA, 8'h30);
    queue_item(KIND_END, 8'h5A);

    // Random: mostly whole strings with random content, some noise items.
    while (pending_items.size() < DRAIN_AT_A + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
          queue_item(KIND_DATA, pick_byte());
        queue_item(KIND_END, 8'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drop idling for the last stretch of the run.
    while (pending_items.size() > CALM_TAIL) @(posedge clk);
    calm <= 1'b1;

    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[quoted_string_escaper] OK");
    end else begin
      $display("[quoted_string_escaper] ERROR");
    end
    $finish;
  end

endmodule
